@@ rtl/qph_pkg.sv @@
`timescale 1ns / 1ps

package qph_pkg;

    // fixed field widths
    localparam int SIZE_W      = 7;
    localparam int LEN_W       = 4;
    localparam int KEY_W       = 64;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 6;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // hash step: h < 127, so h*31 + byte < 2**13
    localparam int HX_W        = 13;
    localparam int HASH_SHIFT  = 5;
    localparam int KTOP        = 12;
    localparam int K_W         = 4;
    localparam int UNIT_W      = HX_W + SIZE_W - 1;

    // defaults
    localparam int DEF_TABLE_DEPTH   = 64;
    localparam int DEF_MAX_KEY_CHARS = 8;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_mem_cmd;

endpackage

@@ rtl/quadratic_probe_hash_table.sv @@
`timescale 1ns / 1ps

// Hash table of short byte-string keys with quadratic probing.
// Input channel (i_valid / o_stall) carries one word: func (insert or search),
// key bytes and key length. Output channel (o_valid / i_stall) returns one
// word per input: status and slot index. The APB port holds table_size at
// byte address 0; writing it empties the table.
// Timing: one word at a time. Hashing runs through a shared conditional
// subtract unit; each key byte takes a load step and 13 reduce steps. Each
// probe is a memory read followed by a check and step; the result is then
// loaded into the output register. An empty key skips hashing and probing
// and goes straight to the output register load.
// The next word is taken once the result sits in the output register; a
// stalled result holds its value, and the next result waits until it is taken.
// Reset (and every table_size write) starts a sweep over all TABLE_DEPTH
// entries that clears the occupied flags; o_stall stays high meanwhile.
// Reset also sets table_size to 64.

module quadratic_probe_hash_table #(
    parameter int TABLE_DEPTH   = qph_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_KEY_CHARS = qph_pkg::DEF_MAX_KEY_CHARS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [qph_pkg::KEY_W-1:0]     i_key_chars,
    input  logic [qph_pkg::LEN_W-1:0]     i_key_length,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [qph_pkg::STATUS_W-1:0]  o_status,
    output logic [qph_pkg::SLOT_W-1:0]    o_slot_index,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qph_pkg::PADDR_W-1:0]   paddr,
    input  logic [qph_pkg::PDATA_W-1:0]   pwdata,
    output logic [qph_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = 8 * MAX_KEY_CHARS;
    localparam int SW = qph_pkg::SIZE_W;
    localparam int LW = qph_pkg::LEN_W;
    localparam int UW = qph_pkg::UNIT_W;
    localparam int XW = qph_pkg::HX_W;
    localparam int KSW = qph_pkg::K_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_HLOAD = 8'b0000_0100,
        S_HRED  = 8'b0000_1000,
        S_PRD   = 8'b0001_0000,
        S_PCHK  = 8'b0010_0000,
        S_PDINC = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0]  r_table_size;
    logic [AW-1:0]  r_clr_cnt, n_clr_cnt;
    logic           r_func, n_func;
    logic [KW-1:0]  r_key, n_key;
    logic [KW-1:0]  r_hkey, n_hkey;
    logic [LW-1:0]  r_len, n_len;
    logic [LW-1:0]  r_bcnt, n_bcnt;
    logic [SW-1:0]  r_size, n_size;
    logic [XW-1:0]  r_x, n_x;
    logic [KSW-1:0] r_k, n_k;
    logic [SW-1:0]  r_p, n_p;
    logic [SW-1:0]  r_d, n_d;
    logic [SW-1:0]  r_cnt, n_cnt;
    qph_pkg::t_status r_res_status, n_res_status;
    logic [qph_pkg::SLOT_W-1:0] r_res_slot, n_res_slot;

    logic           r_out_valid, n_out_valid;
    logic [qph_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [qph_pkg::SLOT_W-1:0]   r_out_slot, n_out_slot;

    logic           cfg_wr;
    logic [SW-1:0]  act_size;
    logic [LW-1:0]  len_c;
    logic [KW-1:0]  key_m;
    logic [UW-1:0]  u_a, u_b, u_res;
    qph_pkg::t_mem_cmd mem_cmd;
    logic [AW-1:0]  mem_addr;
    logic           m_occ;
    logic [KW-1:0]  m_key;
    logic [LW-1:0]  m_len;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == qph_pkg::REG_TABLE_SIZE);
    assign prdata = (paddr[2] == qph_pkg::REG_TABLE_SIZE)
                    ? qph_pkg::PDATA_W'(r_table_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= qph_pkg::SIZE_RESET;
        end else if (cfg_wr) begin
            r_table_size <= pwdata[SW-1:0];
        end
    end

    // size in use, clamped to 1 .. TABLE_DEPTH
    always_comb begin
        if (r_table_size == '0) begin
            act_size = SW'(1);
        end else if (32'(r_table_size) > TABLE_DEPTH) begin
            act_size = SW'(TABLE_DEPTH);
        end else begin
            act_size = r_table_size;
        end
    end

    // incoming key: clamp length and zero the bytes past it
    always_comb begin
        if (i_key_length > LW'(MAX_KEY_CHARS)) begin
            len_c = LW'(MAX_KEY_CHARS);
        end else begin
            len_c = i_key_length;
        end
        for (int j = 0; j < MAX_KEY_CHARS; j++) begin
            key_m[8*j +: 8] = (LW'(j) < len_c) ? i_key_chars[8*j +: 8] : 8'h00;
        end
    end

    qph_csub #(
        .W (UW)
    ) u_csub (
        .i_a   (u_a),
        .i_b   (u_b),
        .o_res (u_res)
    );

    qph_store #(
        .DEPTH (TABLE_DEPTH),
        .KW    (KW),
        .AW    (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_cmd  (mem_cmd),
        .i_addr (mem_addr),
        .i_key  (r_key),
        .i_len  (r_len),
        .o_occ  (m_occ),
        .o_key  (m_key),
        .o_len  (m_len)
    );

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_func       = r_func;
        n_key        = r_key;
        n_hkey       = r_hkey;
        n_len        = r_len;
        n_bcnt       = r_bcnt;
        n_size       = r_size;
        n_x          = r_x;
        n_k          = r_k;
        n_p          = r_p;
        n_d          = r_d;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        u_a          = '0;
        u_b          = '0;
        mem_cmd      = '0;
        mem_addr     = AW'(r_p);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func;
                    n_key  = key_m;
                    n_hkey = key_m;
                    n_len  = len_c;
                    n_size = act_size;
                    n_bcnt = '0;
                    n_x    = '0;
                    if (len_c == '0) begin
                        n_res_status = qph_pkg::ST_MISSING;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_HLOAD;
                    end
                end
            end
            S_CLEAR: begin
                mem_cmd.clr = 1'b1;
                mem_addr    = r_clr_cnt;
                n_clr_cnt   = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_HLOAD: begin
                // r_x holds h here; form h*31 + byte
                n_x = XW'({r_x[SW-1:0], {qph_pkg::HASH_SHIFT{1'b0}}})
                      - XW'(r_x[SW-1:0]) + XW'(r_hkey[7:0]);
                n_hkey  = r_hkey >> 8;
                n_k     = KSW'(qph_pkg::KTOP);
                n_state = S_HRED;
            end
            S_HRED: begin
                // restoring reduction by size << k
                u_a = UW'(r_x);
                u_b = UW'(r_size) << r_k;
                n_x = u_res[XW-1:0];
                n_k = r_k - KSW'(1);
                if (r_k == '0) begin
                    n_bcnt = r_bcnt + LW'(1);
                    if (r_bcnt + LW'(1) == r_len) begin
                        n_p     = u_res[SW-1:0];
                        n_d     = (r_size == SW'(1)) ? '0 : SW'(1);
                        n_cnt   = '0;
                        n_state = S_PRD;
                    end else begin
                        n_state = S_HLOAD;
                    end
                end
            end
            S_PRD: begin
                mem_cmd.rd = 1'b1;
                n_state    = S_PCHK;
            end
            S_PCHK: begin
                u_a = UW'(r_p) + UW'(r_d);
                u_b = UW'(r_size);
                if (!m_occ) begin
                    if (r_func == qph_pkg::FUNC_INSERT) begin
                        mem_cmd.wr   = 1'b1;
                        n_res_status = qph_pkg::ST_INSERTED;
                        n_res_slot   = r_p[qph_pkg::SLOT_W-1:0];
                    end else begin
                        n_res_status = qph_pkg::ST_MISSING;
                        n_res_slot   = '0;
                    end
                    n_state = S_DONE;
                end else if (r_func == qph_pkg::FUNC_SEARCH && m_len == r_len
                             && m_key == r_key) begin
                    n_res_status = qph_pkg::ST_FOUND;
                    n_res_slot   = r_p[qph_pkg::SLOT_W-1:0];
                    n_state      = S_DONE;
                end else if (r_cnt == r_size - SW'(1)) begin
                    n_res_status = (r_func == qph_pkg::FUNC_INSERT)
                                   ? qph_pkg::ST_FULL : qph_pkg::ST_MISSING;
                    n_res_slot   = '0;
                    n_state      = S_DONE;
                end else begin
                    // next probe: p += 2i+1 (mod size)
                    n_p     = u_res[SW-1:0];
                    n_cnt   = r_cnt + SW'(1);
                    n_state = S_PDINC;
                end
            end
            S_PDINC: begin
                u_a = UW'(r_d) + UW'(2);
                u_b = UW'(r_size);
                n_d = (r_size == SW'(1)) ? '0 : u_res[SW-1:0];
                mem_cmd.rd = 1'b1;
                n_state    = S_PCHK;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a size write empties the table
        if (cfg_wr) begin
            n_state   = S_CLEAR;
            n_clr_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_hkey       <= n_hkey;
        r_len        <= n_len;
        r_bcnt       <= n_bcnt;
        r_size       <= n_size;
        r_x          <= n_x;
        r_k          <= n_k;
        r_p          <= n_p;
        r_d          <= n_d;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;

endmodule

@@ rtl/qph_csub.sv @@
`timescale 1ns / 1ps

module qph_csub #(
    parameter int W = qph_pkg::UNIT_W
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_res
);

    // one conditional subtract: a mod b when a < 2*b
    always_comb begin
        if (i_a >= i_b) begin
            o_res = i_a - i_b;
        end else begin
            o_res = i_a;
        end
    end

endmodule

@@ rtl/qph_store.sv @@
`timescale 1ns / 1ps

module qph_store #(
    parameter int DEPTH = qph_pkg::DEF_TABLE_DEPTH,
    parameter int KW    = 8 * qph_pkg::DEF_MAX_KEY_CHARS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  qph_pkg::t_mem_cmd          i_cmd,
    input  logic [AW-1:0]              i_addr,
    input  logic [KW-1:0]              i_key,
    input  logic [qph_pkg::LEN_W-1:0]  i_len,
    output logic                       o_occ,
    output logic [KW-1:0]              o_key,
    output logic [qph_pkg::LEN_W-1:0]  o_len
);

    logic                      r_occ_mem [DEPTH];
    logic [KW-1:0]             r_key_mem [DEPTH];
    logic [qph_pkg::LEN_W-1:0] r_len_mem [DEPTH];

    logic                      r_occ_q;
    logic [KW-1:0]             r_key_q;
    logic [qph_pkg::LEN_W-1:0] r_len_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_occ_mem[i_addr] <= 1'b0;
        end else if (i_cmd.wr) begin
            r_occ_mem[i_addr] <= 1'b1;
        end
        if (i_cmd.rd) begin
            r_occ_q <= r_occ_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_key_mem[i_addr] <= i_key;
            r_len_mem[i_addr] <= i_len;
        end
        if (i_cmd.rd) begin
            r_key_q <= r_key_mem[i_addr];
            r_len_q <= r_len_mem[i_addr];
        end
    end

    assign o_occ = r_occ_q;
    assign o_key = r_key_q;
    assign o_len = r_len_q;

endmodule
